@@ hw/rtl/hctc_pkg.sv @@
// Package for the Huffman code table and decode tree unit.
// Holds the item types and the opcode constants; depends on nothing else.
package hctc_pkg;

  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int SYM_W  = 8;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic              coded_bit;
  } hctc_in_t;

  typedef struct packed {
    logic              symbol_valid;
    logic [SYM_W-1:0]  out_symbol;
    logic [CODE_W-1:0] out_code;
    logic [LEN_W-1:0]  out_length;
    logic              found;
    logic              error;
  } hctc_out_t;

endpackage

@@ hw/rtl/hctc_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the node memory and the code table; depends on nothing else.
module hctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/huffman_code_table_codec_unit.sv @@
// Huffman code table and decode tree unit, top level.
// Uses hctc_pkg for item types and opcodes and hctc_ram for the node memory and code table.
//
// The unit takes one item at a time through a small sequencer around a single node memory
// with one read and one write port. A clear item and an encode item for an absent symbol
// finish in the idle state; an encode item for a present symbol reads the code table in
// S_ENC. A decode item reads the child node in S_DEC, or finishes in the idle state when
// the child is missing. A load item takes the first code bit in S_LSTEP, since the root
// lives in registers; each further bit passes S_LRD, S_LSTEP and, for a new node, S_LLINK.
// Each result is held in an output register, so the next item may enter as it is taken. The
// children of the current decode node are kept in registers, so a decode bit needs only one
// node memory read. After reset the tree holds only the root and the table is empty, with no
// clearing pass.
module huffman_code_table_codec_unit #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32,
  parameter int NODE_DEPTH   = 511
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hctc_pkg::hctc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hctc_pkg::hctc_out_t out_data
);

  localparam int NAW       = $clog2(NODE_DEPTH);
  localparam int NCW       = $clog2(NODE_DEPTH + 1);
  localparam int SAW       = $clog2(SYMBOL_COUNT);
  localparam int LEN_LIMIT = (MAX_CODE_LEN < hctc_pkg::CODE_W) ? MAX_CODE_LEN : hctc_pkg::CODE_W;
  localparam int RW        = $clog2(LEN_LIMIT + 1);
  localparam int NODE_W    = 1 + hctc_pkg::SYM_W + 2 * NAW;
  localparam int CT_W      = hctc_pkg::LEN_W + hctc_pkg::CODE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LRD   = 3'd1;
  localparam logic [2:0] S_LSTEP = 3'd2;
  localparam logic [2:0] S_LLINK = 3'd3;
  localparam logic [2:0] S_ENC   = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  hctc_pkg::hctc_out_t         out_data_r, out_data_nxt;
  logic [SYMBOL_COUNT-1:0]     sym_vld_r, sym_vld_nxt;
  logic [NAW-1:0]              root_l_r, root_l_nxt;
  logic [NAW-1:0]              root_rt_r, root_rt_nxt;
  logic [NCW-1:0]              nodes_r, nodes_nxt;
  logic [NAW-1:0]              walk_r, walk_nxt;
  logic [NAW-1:0]              walk_l_r, walk_l_nxt;
  logic [NAW-1:0]              walk_rt_r, walk_rt_nxt;
  logic [NAW-1:0]              cur_r, cur_nxt;
  logic [NAW-1:0]              link_r, link_nxt;
  logic [NODE_W-1:0]           ent_r, ent_nxt;
  logic                        slot_r, slot_nxt;
  logic [hctc_pkg::CODE_W-1:0] bits_r, bits_nxt;
  logic [hctc_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [hctc_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [RW-1:0]               rem_r, rem_nxt;
  logic [hctc_pkg::SYM_W-1:0]  lsym_r, lsym_nxt;
  logic [NAW-1:0]              dchild_r, dchild_nxt;

  logic                        acc;
  logic                        sym_ok;
  logic [SAW-1:0]              sym_idx;
  logic                        sym_found;
  logic [hctc_pkg::LEN_W-1:0]  len_sat;
  logic [hctc_pkg::LEN_W-1:0]  align_sh;
  logic [NAW-1:0]              wk_l, wk_rt, dec_child;
  logic                        dec_err;
  logic                        r_leaf;
  logic [hctc_pkg::SYM_W-1:0]  r_sym;
  logic [NAW-1:0]              r_l, r_rt;
  logic [NAW-1:0]              cur_l, cur_rt, ld_child;
  logic                        ld_bit, ld_last, nodes_full;
  logic [NAW-1:0]              new_idx;
  logic                        commit, emit;
  hctc_pkg::hctc_out_t         res;

  logic                        nd_we;
  logic [NAW-1:0]              nd_waddr, nd_raddr;
  logic [NODE_W-1:0]           nd_wdata, nd_rdata;
  logic [CT_W-1:0]             ct_rdata;

  hctc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

  hctc_ram #(.WIDTH(CT_W), .DEPTH(SYMBOL_COUNT)) u_code_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (lsym_r[SAW-1:0]),
    .wdata ({len_r, code_r}),
    .raddr (in_data.symbol[SAW-1:0]),
    .rdata (ct_rdata)
  );

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sym_ok    = {1'b0, in_data.symbol} < 9'(SYMBOL_COUNT);
  assign sym_idx   = in_data.symbol[SAW-1:0];
  assign sym_found = sym_ok && sym_vld_r[sym_idx];
  assign len_sat   = (in_data.code_length > hctc_pkg::LEN_W'(LEN_LIMIT)) ?
                     hctc_pkg::LEN_W'(LEN_LIMIT) : in_data.code_length;
  assign align_sh  = hctc_pkg::LEN_W'(hctc_pkg::CODE_W) - len_sat;

  assign wk_l      = (walk_r == '0) ? root_l_r : walk_l_r;
  assign wk_rt     = (walk_r == '0) ? root_rt_r : walk_rt_r;
  assign dec_child = in_data.coded_bit ? wk_rt : wk_l;
  assign dec_err   = (dec_child == '0) || (NCW'(dec_child) >= nodes_r);

  assign r_leaf    = nd_rdata[NODE_W-1];
  assign r_sym     = nd_rdata[NODE_W-2 -: hctc_pkg::SYM_W];
  assign r_l       = nd_rdata[2*NAW-1:NAW];
  assign r_rt      = nd_rdata[NAW-1:0];

  assign cur_l      = (cur_r == '0) ? root_l_r : r_l;
  assign cur_rt     = (cur_r == '0) ? root_rt_r : r_rt;
  assign ld_bit     = bits_r[hctc_pkg::CODE_W-1];
  assign ld_child   = ld_bit ? cur_rt : cur_l;
  assign ld_last    = (rem_r == RW'(1));
  assign nodes_full = (nodes_r >= NCW'(NODE_DEPTH));
  assign new_idx    = nodes_r[NAW-1:0];

  assign nd_raddr   = (state_r == S_LRD) ? cur_r : dec_child;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    sym_vld_nxt   = sym_vld_r;
    root_l_nxt    = root_l_r;
    root_rt_nxt   = root_rt_r;
    nodes_nxt     = nodes_r;
    walk_nxt      = walk_r;
    walk_l_nxt    = walk_l_r;
    walk_rt_nxt   = walk_rt_r;
    cur_nxt       = cur_r;
    link_nxt      = link_r;
    ent_nxt       = ent_r;
    slot_nxt      = slot_r;
    bits_nxt      = bits_r;
    code_nxt      = code_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    lsym_nxt      = lsym_r;
    dchild_nxt    = dchild_r;
    nd_we         = 1'b0;
    nd_waddr      = new_idx;
    nd_wdata      = '0;
    commit        = 1'b0;
    emit          = 1'b0;
    res           = '0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_data.opcode)
            hctc_pkg::OP_LOAD: begin
              if (in_data.code_length == '0 || !sym_ok) begin
                emit = 1'b1;
              end else begin
                bits_nxt  = in_data.code_word << align_sh;
                code_nxt  = in_data.code_word & ({hctc_pkg::CODE_W{1'b1}} >> align_sh);
                len_nxt   = len_sat;
                rem_nxt   = RW'(len_sat);
                lsym_nxt  = in_data.symbol;
                cur_nxt   = '0;
                state_nxt = S_LSTEP;
              end
            end
            hctc_pkg::OP_ENCODE: begin
              if (sym_found) begin
                state_nxt = S_ENC;
              end else begin
                emit = 1'b1;
              end
            end
            hctc_pkg::OP_DECODE: begin
              if (dec_err) begin
                emit      = 1'b1;
                res.error = 1'b1;
                walk_nxt  = '0;
              end else begin
                dchild_nxt = dec_child;
                state_nxt  = S_DEC;
              end
            end
            hctc_pkg::OP_CLEAR: begin
              emit        = 1'b1;
              sym_vld_nxt = '0;
              root_l_nxt  = '0;
              root_rt_nxt = '0;
              nodes_nxt   = NCW'(1);
              walk_nxt    = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_LRD: begin
        state_nxt = S_LSTEP;
      end
      S_LSTEP: begin
        if (ld_child != '0) begin
          cur_nxt  = ld_child;
          bits_nxt = bits_r << 1;
          rem_nxt  = rem_r - RW'(1);
          if (ld_last) begin
            commit = 1'b1;
          end else begin
            state_nxt = S_LRD;
          end
        end else if (nodes_full) begin
          emit      = 1'b1;
          res.error = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          nd_we     = 1'b1;
          nd_waddr  = new_idx;
          nd_wdata  = {ld_last, lsym_r, {NAW{1'b0}}, {NAW{1'b0}}};
          nodes_nxt = nodes_r + NCW'(1);
          cur_nxt   = new_idx;
          bits_nxt  = bits_r << 1;
          rem_nxt   = rem_r - RW'(1);
          if (cur_r == '0) begin
            if (ld_bit) begin
              root_rt_nxt = new_idx;
            end else begin
              root_l_nxt = new_idx;
            end
            if (ld_last) begin
              commit = 1'b1;
            end else begin
              state_nxt = S_LRD;
            end
          end else begin
            ent_nxt   = nd_rdata;
            slot_nxt  = ld_bit;
            link_nxt  = cur_r;
            state_nxt = S_LLINK;
          end
        end
      end
      S_LLINK: begin
        nd_we    = 1'b1;
        nd_waddr = link_r;
        if (slot_r) begin
          nd_wdata = {ent_r[NODE_W-1:NAW], cur_r};
        end else begin
          nd_wdata = {ent_r[NODE_W-1:2*NAW], cur_r, ent_r[NAW-1:0]};
        end
        if (link_r == walk_r) begin
          if (slot_r) begin
            walk_rt_nxt = cur_r;
          end else begin
            walk_l_nxt = cur_r;
          end
        end
        if (rem_r == '0) begin
          commit = 1'b1;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_ENC: begin
        emit           = 1'b1;
        res.found      = 1'b1;
        res.out_code   = ct_rdata[hctc_pkg::CODE_W-1:0];
        res.out_length = ct_rdata[CT_W-1:hctc_pkg::CODE_W];
        state_nxt      = S_IDLE;
      end
      S_DEC: begin
        emit = 1'b1;
        if (r_leaf) begin
          res.symbol_valid = 1'b1;
          res.out_symbol   = r_sym;
          walk_nxt         = '0;
        end else begin
          walk_nxt    = dchild_r;
          walk_l_nxt  = r_l;
          walk_rt_nxt = r_rt;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (commit) begin
      sym_vld_nxt[lsym_r[SAW-1:0]] = 1'b1;
      emit      = 1'b1;
      state_nxt = S_IDLE;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sym_vld_r   <= '0;
      root_l_r    <= '0;
      root_rt_r   <= '0;
      nodes_r     <= NCW'(1);
      walk_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sym_vld_r   <= sym_vld_nxt;
      root_l_r    <= root_l_nxt;
      root_rt_r   <= root_rt_nxt;
      nodes_r     <= nodes_nxt;
      walk_r      <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    walk_l_r   <= walk_l_nxt;
    walk_rt_r  <= walk_rt_nxt;
    cur_r      <= cur_nxt;
    link_r     <= link_nxt;
    ent_r      <= ent_nxt;
    slot_r     <= slot_nxt;
    bits_r     <= bits_nxt;
    code_r     <= code_nxt;
    len_r      <= len_nxt;
    rem_r      <= rem_nxt;
    lsym_r     <= lsym_nxt;
    dchild_r   <= dchild_nxt;
  end

endmodule
